@@ src/bmp_pkg.sv @@
// Package with constants and types of the binomial engine.
package bmp_pkg;

    localparam int unsigned MODP_INT     = 998244353;
    localparam logic [29:0] MODP         = 30'd998244353;
    localparam logic [29:0] EXP_INV      = 30'd998244351;
    localparam int unsigned DEF_DEPTH    = 1024;
    localparam int unsigned VAL_W        = 30;
    localparam int unsigned ARG_W        = 10;

    typedef enum logic [1:0] {
        OP_BINOM    = 2'd0,
        OP_MULTISET = 2'd1,
        OP_CATALAN  = 2'd2,
        OP_NONE     = 2'd3
    } t_opcode;

    typedef enum logic [2:0] {
        B_IDLE,
        B_FACT,
        B_POW,
        B_INV,
        B_DONE
    } t_build_state;

    // Control and status handed from the build sequencer to the query path.
    typedef struct packed {
        logic        ready;
        logic [16:0] top;
    } t_build_status;

endpackage

@@ src/binomial_mod_prime_engine.sv @@
// Top level of the binomial engine: table build sequencer and pipelined query path.
// Throughput: one query per cycle while busy is low; the receiver cannot stall, so results
// never back up. After reset and after each table_size write a build pass holds busy high
// while it computes the factorials, the inverse of the top factorial by exponentiation,
// and then the inverse factorials downward.
// Reset is synchronous and active low and starts the build for table_size 0.
module binomial_mod_prime_engine #(
    parameter int unsigned TABLE_DEPTH = bmp_pkg::DEF_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [9:0]  i_cfg_data,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_opcode,
    input  logic [9:0]  i_arg_a,
    input  logic [9:0]  i_arg_b,
    output logic        o_strobe,
    output logic [29:0] o_value,
    output logic        o_out_of_range
);
    import bmp_pkg::*;

    localparam int unsigned AW  = $clog2(TABLE_DEPTH);
    localparam int unsigned MUL_LAT = 5;
    localparam int unsigned IW  = 17;
    localparam logic [IW-1:0] MAX_N = IW'(TABLE_DEPTH - 2);

    logic [9:0]           r_table_size;
    logic                 r_rebuild;
    t_build_state         r_bstate, n_bstate;
    logic [IW-1:0]        r_top;
    logic [IW-1:0]        r_idx;
    logic [3:0]           r_wait;
    logic [4:0]           r_bit;
    logic                 r_sq_phase;
    logic [VAL_W-1:0]     r_acc, r_base, r_last;
    t_build_status        w_status;

    logic [VAL_W-1:0]     r_fact  [TABLE_DEPTH];
    logic [VAL_W-1:0]     r_inv_a [TABLE_DEPTH];
    logic [VAL_W-1:0]     r_inv_b [TABLE_DEPTH];

    logic [VAL_W-1:0]     w_bx, w_by, w_bp;
    logic                 w_bdone;
    logic [IW-1:0]        w_sat;

    assign w_sat   = ({7'd0, r_table_size} > MAX_N) ? MAX_N : {7'd0, r_table_size};
    assign w_bdone = (r_wait == 4'(MUL_LAT));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_size <= '0;
            r_rebuild    <= 1'b1;
        end else if (i_cfg_we) begin
            r_table_size <= i_cfg_data;
            r_rebuild    <= 1'b1;
        end else if (r_bstate == B_IDLE) begin
            r_rebuild    <= 1'b0;
        end
    end

    always_comb begin
        n_bstate = r_bstate;
        case (r_bstate)
            B_IDLE:  if (r_rebuild) n_bstate = B_FACT;
            B_FACT:  if (w_bdone && r_idx == r_top) n_bstate = B_POW;
            B_POW:   if (w_bdone && r_sq_phase && r_bit == 5'd29) n_bstate = B_INV;
            B_INV:   if (w_bdone && r_idx == '0) n_bstate = B_DONE;
            B_DONE:  if (r_rebuild) n_bstate = B_FACT;
            default: n_bstate = B_IDLE;
        endcase
        if (i_cfg_we) n_bstate = B_IDLE;
    end

    always_comb begin
        w_bx = r_last;
        w_by = VAL_W'(r_idx);
        case (r_bstate)
            B_FACT:  begin w_bx = r_last; w_by = VAL_W'(r_idx); end
            B_POW:   begin
                w_bx = r_sq_phase ? r_base : r_acc;
                w_by = r_base;
            end
            B_INV:   begin w_bx = r_last; w_by = VAL_W'(r_idx + 1'b1); end
            default: begin w_bx = r_last; w_by = r_last; end
        endcase
    end

    bmp_modmul u_bmul (.i_clk(i_clk), .i_x(w_bx), .i_y(w_by), .o_p(w_bp));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bstate <= B_IDLE;
            r_wait   <= '0;
            r_idx    <= '0;
        end else begin
            r_bstate <= n_bstate;
            if (r_bstate == B_IDLE || (r_bstate == B_DONE && r_rebuild) || i_cfg_we) begin
                r_top      <= w_sat + 1'b1;
                r_idx      <= IW'(1);
                r_last     <= 30'd1;
                r_wait     <= '0;
                r_fact[0]  <= 30'd1;
            end else if (r_bstate == B_FACT || r_bstate == B_POW || r_bstate == B_INV) begin
                r_wait <= w_bdone ? '0 : r_wait + 1'b1;
                if (w_bdone) begin
                    case (r_bstate)
                        B_FACT: begin
                            r_fact[r_idx[AW-1:0]] <= w_bp;
                            r_last <= w_bp;
                            r_idx  <= r_idx + 1'b1;
                            if (r_idx == r_top) begin
                                r_base     <= w_bp;
                                r_acc      <= 30'd1;
                                r_bit      <= 5'd0;
                                r_sq_phase <= 1'b0;
                            end
                        end
                        B_POW: begin
                            if (!r_sq_phase) begin
                                if (EXP_INV[r_bit]) r_acc <= w_bp;
                                r_sq_phase <= 1'b1;
                            end else begin
                                r_base     <= w_bp;
                                r_sq_phase <= 1'b0;
                                r_bit      <= (r_bit == 5'd29) ? 5'd0 : r_bit + 1'b1;
                                if (r_bit == 5'd29) begin
                                    r_inv_a[r_top[AW-1:0]] <= r_acc;
                                    r_inv_b[r_top[AW-1:0]] <= r_acc;
                                    r_last <= r_acc;
                                    r_idx  <= r_top - 1'b1;
                                end
                            end
                        end
                        B_INV: begin
                            r_inv_a[r_idx[AW-1:0]] <= w_bp;
                            r_inv_b[r_idx[AW-1:0]] <= w_bp;
                            r_last <= w_bp;
                            r_idx  <= r_idx - 1'b1;
                        end
                        default: r_last <= r_last;
                    endcase
                end
            end
        end
    end

    // The square step of the last bit leaves the POW state; the transition fires on bit 29.
    assign w_status.ready = (r_bstate == B_DONE) && !r_rebuild;
    assign w_status.top   = r_top;
    assign busy = !w_status.ready;

    // Query stage 1: index computation and range checks.
    logic            r_v1, r_v2;
    logic [IW-1:0]   r_up, r_lo1, r_lo2;
    logic            r_z1, r_z2, r_oor1;
    logic            r_cat1;
    logic [IW-1:0]   w_up, w_lo1, w_lo2;
    logic            w_z1, w_z2, w_oor, w_cat;
    logic [IW-1:0]   w_a, w_b;

    always_comb begin
        w_a   = {7'd0, i_arg_a};
        w_b   = {7'd0, i_arg_b};
        w_cat = 1'b0;
        w_up  = '0;
        w_lo1 = '0;
        w_lo2 = '0;
        w_z1  = 1'b1;
        w_z2  = 1'b1;
        w_oor = 1'b0;
        case (t_opcode'(i_opcode))
            OP_BINOM: begin
                w_up = w_a; w_lo1 = w_b;
                w_z1 = w_a < w_b;
                w_oor = !w_z1 && (w_a > w_status.top);
            end
            OP_MULTISET: begin
                w_lo1 = w_b;
                w_z1  = (w_a == '0);
                w_up  = w_a + w_b - 1'b1;
                w_oor = !w_z1 && (w_up > w_status.top);
            end
            OP_CATALAN: begin
                w_cat = 1'b1;
                w_up  = w_a << 1;
                w_lo1 = w_a;
                w_lo2 = w_a - 1'b1;
                w_z1  = 1'b0;
                w_z2  = (w_a == '0);
                w_oor = w_up > w_status.top;
            end
            default: w_oor = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0; r_v2 <= 1'b0;
        end else begin
            r_v1 <= start && !busy;
            r_v2 <= r_v1;
        end
        r_up <= w_up; r_lo1 <= w_lo1; r_lo2 <= w_lo2;
        r_z1 <= w_z1 || w_oor; r_z2 <= w_z2 || !w_cat || w_oor;
        r_oor1 <= w_oor; r_cat1 <= w_cat;
    end

    // Stage 2: table reads, registered.
    logic [VAL_W-1:0] r_f_up, r_i_lo1, r_i_d1, r_i_lo2, r_i_d2;
    logic             r_z1b, r_z2b, r_oor2;
    always_ff @(posedge i_clk) begin
        r_f_up  <= r_fact[r_up[AW-1:0]];
        r_i_lo1 <= r_inv_a[r_lo1[AW-1:0]];
        r_i_d1  <= r_inv_a[AW'(r_up - r_lo1)];
        r_i_lo2 <= r_inv_b[r_lo2[AW-1:0]];
        r_i_d2  <= r_inv_b[AW'(r_up - r_lo2)];
        r_z1b <= r_z1; r_z2b <= r_z2; r_oor2 <= r_oor1;
    end

    // Stage 3 on: two rounds of modular multiplication per term.
    logic [VAL_W-1:0] w_m1a, w_m2a, w_m1b, w_m2b;
    logic [VAL_W-1:0] r_fd [MUL_LAT];
    logic [MUL_LAT-1:0] r_zd1, r_zd2, r_od, r_vd;
    logic [MUL_LAT-1:0] r_zq1, r_zq2, r_oq, r_vq;

    bmp_modmul u_m1a (.i_clk(i_clk), .i_x(r_i_lo1), .i_y(r_i_d1), .o_p(w_m1a));
    bmp_modmul u_m2a (.i_clk(i_clk), .i_x(r_i_lo2), .i_y(r_i_d2), .o_p(w_m2a));
    bmp_modmul u_m1b (.i_clk(i_clk), .i_x(w_m1a), .i_y(r_fd[MUL_LAT-1]), .o_p(w_m1b));
    bmp_modmul u_m2b (.i_clk(i_clk), .i_x(w_m2a), .i_y(r_fd[MUL_LAT-1]), .o_p(w_m2b));

    always_ff @(posedge i_clk) begin
        r_fd[0] <= r_f_up;
        for (int k = 1; k < MUL_LAT; k++) r_fd[k] <= r_fd[k-1];
        r_zd1 <= {r_zd1[MUL_LAT-2:0], r_z1b};
        r_zd2 <= {r_zd2[MUL_LAT-2:0], r_z2b};
        r_od  <= {r_od[MUL_LAT-2:0], r_oor2};
        r_zq1 <= {r_zq1[MUL_LAT-2:0], r_zd1[MUL_LAT-1]};
        r_zq2 <= {r_zq2[MUL_LAT-2:0], r_zd2[MUL_LAT-1]};
        r_oq  <= {r_oq[MUL_LAT-2:0], r_od[MUL_LAT-1]};
        if (!i_rst_n) begin
            r_vd <= '0; r_vq <= '0;
        end else begin
            r_vd <= {r_vd[MUL_LAT-2:0], r_v2};
            r_vq <= {r_vq[MUL_LAT-2:0], r_vd[MUL_LAT-1]};
        end
    end

    // The factor delay matches the first multiplier, so it meets that product.
    // Final subtract and output register.
    logic [VAL_W-1:0] w_t1, w_t2;
    logic [VAL_W:0]   w_diff;
    logic             r_strobe, r_oor;
    logic [VAL_W-1:0] r_value;

    always_comb begin
        w_t1   = r_zq1[MUL_LAT-1] ? '0 : w_m1b;
        w_t2   = r_zq2[MUL_LAT-1] ? '0 : w_m2b;
        w_diff = {1'b0, w_t1} + ((w_t1 >= w_t2) ? 31'd0 : {1'b0, MODP}) - {1'b0, w_t2};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= r_vq[MUL_LAT-1];
        end
        r_oor   <= r_oq[MUL_LAT-1];
        r_value <= r_oq[MUL_LAT-1] ? '0 : w_diff[VAL_W-1:0];
    end

    assign o_strobe       = r_strobe;
    assign o_value        = r_value;
    assign o_out_of_range = r_oor;

`ifndef SYNTHESIS
    a_oor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_out_of_range |-> o_value == '0)
        else $error("out of range result carries a nonzero value");
    a_value_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> o_value < MODP)
        else $error("result not reduced");
    a_busy_during_build: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> busy)
        else $error("queries accepted right after a table size write");
`endif
endmodule

@@ src/bmp_modmul.sv @@
// Pipelined modular multiplier: product, Barrett estimate, correction, over five stages.
module bmp_modmul (
    input  logic                  i_clk,
    input  logic [bmp_pkg::VAL_W-1:0] i_x,
    input  logic [bmp_pkg::VAL_W-1:0] i_y,
    output logic [bmp_pkg::VAL_W-1:0] o_p
);
    import bmp_pkg::*;

    // m = floor(2^60 / p), 31 bits.
    localparam logic [31:0] BARRETT_M = 32'd1154949187;

    logic [59:0] r_prod;
    logic [59:0] r_prod2;
    logic [30:0] r_qhi;
    logic [59:0] r_prod3;
    logic [61:0] r_qp;
    logic [31:0] r_rem;
    logic [31:0] n_rem;
    logic [29:0] r_out;
    logic [62:0] w_q;
    logic [31:0] w_r1;

    assign w_q = {3'd0, r_prod[59:29]} * {31'd0, BARRETT_M};

    always_comb begin
        n_rem = r_prod3[31:0] - r_qp[31:0];
        w_r1  = (r_rem >= {2'd0, MODP}) ? r_rem - {2'd0, MODP} : r_rem;
    end

    always_ff @(posedge i_clk) begin
        r_prod  <= {30'd0, i_x} * {30'd0, i_y};
        r_prod2 <= r_prod;
        r_qhi   <= w_q[61:31];
        r_prod3 <= r_prod2;
        r_qp    <= {31'd0, r_qhi} * {32'd0, MODP};
        r_rem   <= n_rem;
        r_out   <= (w_r1 >= {2'd0, MODP}) ? w_r1[29:0] - MODP : w_r1[29:0];
    end

    assign o_p = r_out;
endmodule
